### rtl/core/csvt_pkg.sv
// Shared constants, types and helper functions for the CSV field tokenizer.
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_UNQ    = 2'd1;
  localparam logic [1:0] MODE_QUOTED = 2'd2;
  localparam logic [1:0] MODE_CLOSE  = 2'd3;

  localparam logic [1:0] BOM_DONE = 2'd3;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FIELD  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;

  localparam int MAX_RES = 4;
  localparam int RES_IDX_W = 2;
  localparam int RES_CNT_W = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } result_t;

  // One accepted word's worth of results, oldest in slot 0.
  typedef struct packed {
    logic [RES_CNT_W-1:0]  count;
    result_t [MAX_RES-1:0] res;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      default: b = 8'hBF;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/csvt_ifs.sv
// Valid/ready channel interfaces for raw text words and token words.
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source(output valid, output in_byte, output stream_end, input ready);
  modport sink(input valid, input in_byte, input stream_end, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source(output valid, output out_byte, output kind, output last, input ready);
  modport sink(input valid, input out_byte, input kind, input last, output ready);
endinterface

### rtl/core/csvt_front.sv
// Front end: accepts text words, tracks parse state and builds result lists.
module csvt_front (
  input  logic                  clk,
  input  logic                  rst,
  csvt_in_if.sink               text,
  input  logic                  full,
  output csvt_pkg::push_t       push
);

  logic [1:0] parse_mode;
  logic [1:0] bom_progress;
  logic       line_started;
  logic [1:0] parse_mode_next;
  logic [1:0] bom_progress_next;
  logic       line_started_next;
  csvt_pkg::entry_t entry;
  logic       accept;

  assign text.ready = !full;
  assign accept = text.valid && text.ready;

  always_comb begin
    logic [1:0] mode;
    logic [1:0] bom;
    logic       ls;
    logic [csvt_pkg::RES_CNT_W-1:0] n;
    logic       do_close;
    logic       do_parse;
    logic [7:0] b;

    mode = parse_mode;
    bom = bom_progress;
    ls = line_started;
    n = '0;
    do_close = 1'b0;
    do_parse = 1'b0;
    b = text.in_byte;
    entry.res = '0;

    if (text.stream_end) begin
      // With nothing on the line the state already sits at line start.
      do_close = line_started;
    end else if (b == csvt_pkg::CH_CR) begin
      ls = 1'b1;
    end else if (b == csvt_pkg::CH_LF) begin
      do_close = 1'b1;
    end else begin
      ls = 1'b1;
      if (bom != csvt_pkg::BOM_DONE && b == csvt_pkg::bom_byte(bom)) begin
        bom = bom + 2'd1;
      end else begin
        do_parse = 1'b1;
      end
    end

    // A partial mark is replayed as data; it can only be pending at field start.
    if (do_close || do_parse) begin
      for (int i = 0; i < 2; i++) begin
        if (bom != csvt_pkg::BOM_DONE && 2'(i) < bom) begin
          entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{csvt_pkg::bom_byte(2'(i)),
                                                    csvt_pkg::KIND_DATA};
          n = n + 3'd1;
          mode = csvt_pkg::MODE_UNQ;
        end
      end
      bom = csvt_pkg::BOM_DONE;
    end

    if (do_parse) begin
      unique case (mode)
        csvt_pkg::MODE_START: begin
          if (b == csvt_pkg::CH_QUOTE) begin
            mode = csvt_pkg::MODE_QUOTED;
          end else if (b == csvt_pkg::CH_COMMA) begin
            entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{8'd0, csvt_pkg::KIND_FIELD};
            n = n + 3'd1;
          end else begin
            entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{b, csvt_pkg::KIND_DATA};
            n = n + 3'd1;
            mode = csvt_pkg::MODE_UNQ;
          end
        end
        csvt_pkg::MODE_UNQ: begin
          if (b == csvt_pkg::CH_COMMA) begin
            entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{8'd0, csvt_pkg::KIND_FIELD};
            mode = csvt_pkg::MODE_START;
          end else begin
            entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{b, csvt_pkg::KIND_DATA};
          end
          n = n + 3'd1;
        end
        csvt_pkg::MODE_QUOTED: begin
          if (b == csvt_pkg::CH_QUOTE) begin
            mode = csvt_pkg::MODE_CLOSE;
          end else begin
            entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{b, csvt_pkg::KIND_DATA};
            n = n + 3'd1;
          end
        end
        default: begin
          if (b == csvt_pkg::CH_QUOTE) begin
            entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{b, csvt_pkg::KIND_DATA};
            n = n + 3'd1;
            mode = csvt_pkg::MODE_QUOTED;
          end else if (b == csvt_pkg::CH_COMMA) begin
            entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{8'd0, csvt_pkg::KIND_FIELD};
            n = n + 3'd1;
            mode = csvt_pkg::MODE_START;
          end else begin
            // Text right after a closing quote opens a new unquoted field.
            entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{8'd0, csvt_pkg::KIND_FIELD};
            n = n + 3'd1;
            entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{b, csvt_pkg::KIND_DATA};
            n = n + 3'd1;
            mode = csvt_pkg::MODE_UNQ;
          end
        end
      endcase
    end

    if (do_close) begin
      if (mode != csvt_pkg::MODE_START) begin
        entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{8'd0, csvt_pkg::KIND_FIELD};
        n = n + 3'd1;
      end
      entry.res[n[csvt_pkg::RES_IDX_W-1:0]] = '{8'd0, csvt_pkg::KIND_RECORD};
      n = n + 3'd1;
      mode = csvt_pkg::MODE_START;
      bom = 2'd0;
      ls = 1'b0;
    end

    entry.count = n;
    parse_mode_next = mode;
    bom_progress_next = bom;
    line_started_next = ls;
  end

  assign push.push = accept && (entry.count != '0);
  assign push.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= csvt_pkg::MODE_START;
      bom_progress <= 2'd0;
      line_started <= 1'b0;
    end else if (accept) begin
      parse_mode <= parse_mode_next;
      bom_progress <= bom_progress_next;
      line_started <= line_started_next;
    end
  end

endmodule

### rtl/core/csvt_queue.sv
// Short queue of result lists between the front end and the back end.
module csvt_queue (
  input  logic             clk,
  input  logic             rst,
  input  csvt_pkg::push_t  push,
  output logic             full,
  output csvt_pkg::head_t  head,
  input  logic             pop
);

  csvt_pkg::entry_t entries [csvt_pkg::QUEUE_DEPTH];
  logic [csvt_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [csvt_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [csvt_pkg::QUEUE_CNT_W-1:0] count;
  logic do_pop;

  assign full = (count == csvt_pkg::QUEUE_CNT_W'(csvt_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];
  assign do_pop = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/csvt_back.sv
// Back end: walks each result list and drives the token channel from a register.
module csvt_back (
  input  logic             clk,
  input  logic             rst,
  input  csvt_pkg::head_t  head,
  output logic             pop,
  csvt_out_if.source       token
);

  logic [csvt_pkg::RES_IDX_W-1:0] sub;
  logic       valid;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;
  logic       load;
  logic       sub_last;
  csvt_pkg::result_t cur;

  assign cur = head.entry.res[sub];
  assign sub_last = ({1'b0, sub} == head.entry.count - 3'd1);
  assign load = head.valid && (!valid || token.ready);
  assign pop = load && sub_last;

  assign token.valid = valid;
  assign token.out_byte = out_byte;
  assign token.kind = kind;
  assign token.last = last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= cur.data;
      kind <= cur.kind;
      last <= sub_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sub <= '0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        sub <= sub_last ? '0 : sub + 1'b1;
      end else if (token.ready) begin
        valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: front end, result queue and back end.
// A word's results pass through the result queue and then the output register.
// While the receiver keeps ready high, one word per cycle is taken when each word gives
// at most one result; a word with several results holds the single output register
// until they are all out. Words giving no result (CR, byte order mark bytes) emit nothing.
// Reset (synchronous, rst high) returns to line start and empties queue and output.
module csv_field_tokenizer (
  input  logic       clk,
  input  logic       rst,
  csvt_in_if.sink    text,
  csvt_out_if.source token
);

  csvt_pkg::push_t push;
  csvt_pkg::head_t head;
  logic            full;
  logic            pop;

  csvt_front u_front (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .full (full),
    .push (push)
  );

  csvt_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  csvt_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .pop   (pop),
    .token (token)
  );

endmodule

### dv/tb_top.sv
// Testbench for the CSV field tokenizer: byte stimulus, token prediction and checks.
`timescale 1ns / 100ps

module tb_top;
  import csvt_pkg::*;

  localparam logic [7:0] MARK0 = 8'hEF;
  localparam logic [7:0] MARK1 = 8'hBB;
  localparam logic [7:0] MARK2 = 8'hBF;
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 160;
  localparam int PHASE_WORDS = 75;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } token_t;

  // Tracks the tokenizer state and the tokens still owed by the block.
  class token_board;
    logic [1:0] mode;
    logic [1:0] mark_cnt;
    logic       line_seen;
    logic       rec_open;
    logic [7:0] mark_seq [3];
    token_t     pending[$];
    token_t     step_out[$];
    int         errors;

    function new();
      mark_seq = '{MARK0, MARK1, MARK2};
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      mode = MODE_START;
      mark_cnt = 2'd0;
      line_seen = 1'b0;
      rec_open = 1'b0;
    endfunction

    function void emit(logic [7:0] b, logic [1:0] k);
      token_t t;
      if (step_out.size() >= MAX_RES) return;
      t.data = b;
      t.kind = k;
      t.last = 1'b0;
      step_out.insert(step_out.size(), t);
    endfunction

    function void end_field();
      emit(8'h00, KIND_FIELD);
      rec_open = 1'b1;
      mode = MODE_START;
    endfunction

    // One byte that is neither CR nor LF.
    function void take_char(logic [7:0] b);
      case (mode)
        MODE_START: begin
          if (b == CH_QUOTE) mode = MODE_QUOTED;
          else if (b == CH_COMMA) end_field();
          else begin
            emit(b, KIND_DATA);
            mode = MODE_UNQ;
          end
        end
        MODE_UNQ: begin
          if (b == CH_COMMA) end_field();
          else emit(b, KIND_DATA);
        end
        MODE_QUOTED: begin
          if (b == CH_QUOTE) mode = MODE_CLOSE;
          else emit(b, KIND_DATA);
        end
        default: begin
          if (b == CH_QUOTE) begin
            emit(b, KIND_DATA);
            mode = MODE_QUOTED;
          end else if (b == CH_COMMA) begin
            end_field();
          end else begin
            end_field();
            emit(b, KIND_DATA);
            mode = MODE_UNQ;
          end
        end
      endcase
    endfunction

    // A partially matched byte order mark goes out as plain data.
    function void replay_mark();
      int i;
      if (mark_cnt < BOM_DONE) begin
        for (i = 0; i < mark_cnt; i++) take_char(mark_seq[i]);
      end
      mark_cnt = BOM_DONE;
    endfunction

    function void close_line();
      replay_mark();
      if (mode != MODE_START) end_field();
      emit(8'h00, KIND_RECORD);
      clear_line();
    endfunction

    function void note_word(logic [7:0] b, logic e);
      step_out.delete();
      if (e) begin
        if (line_seen) close_line();
        else clear_line();
      end else if (b == CH_CR) begin
        line_seen = 1'b1;
      end else if (b == CH_LF) begin
        close_line();
      end else begin
        line_seen = 1'b1;
        if (mark_cnt < BOM_DONE && b == mark_seq[mark_cnt]) begin
          mark_cnt++;
        end else begin
          replay_mark();
          take_char(b);
        end
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) pending.insert(pending.size(), step_out[i]);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_token(logic [7:0] b, logic [1:0] k, logic l);
      token_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected token: expected none, got byte %h kind %0d last %0b",
                 $time, b, k, l);
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("out_byte", want.data, b);
      check_field("kind", {6'd0, want.kind}, {6'd0, k});
      check_field("last", {7'd0, want.last}, {7'd0, l});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  csvt_in_if  text();
  csvt_out_if token();

  token_board sb;
  int  words_sent = 0;
  int  src_idle_pct = 0;
  int  rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  int  stuck_cycles = 0;
  logic [8:0] dir_words[$];

  csv_field_tokenizer DUT (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .token(token)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) token.ready <= 1'b0;
    else token.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && token.valid && token.ready) sb.check_token(token.out_byte, token.kind, token.last);
  end

  always @(posedge clk) begin
    if (rst || (text.valid && text.ready) || (token.valid && token.ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles, %0d tokens outstanding",
               $time, STUCK_LIMIT, sb.pending.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      text.valid <= 1'b0;
      @(posedge clk);
    end
    text.valid <= 1'b1;
    text.in_byte <= b;
    text.stream_end <= e;
    do @(posedge clk); while (!text.ready);
    sb.note_word(b, e);
    words_sent++;
  endtask

  // Plain field text: never a delimiter, quote or line break.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      if ($urandom_range(3) == 0) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(8'h7E, 8'h20));
    end while (b == CH_LF || b == CH_CR || b == CH_COMMA || b == CH_QUOTE);
    return b;
  endfunction

  task automatic send_record();
    int nf;
    int len;
    int r;
    int f;
    r = $urandom_range(99);
    if (r < 20) begin
      send_word(MARK0, 1'b0);
      send_word(MARK1, 1'b0);
      send_word(MARK2, 1'b0);
    end else if (r < 30) begin
      send_word(MARK0, 1'b0);
      if ($urandom_range(1)) send_word(MARK1, 1'b0);
    end
    nf = $urandom_range(4);
    for (f = 0; f < nf; f++) begin
      if (f > 0) send_word(CH_COMMA, 1'b0);
      len = $urandom_range(5);
      if ($urandom_range(1)) begin
        send_word(CH_QUOTE, 1'b0);
        repeat (len) begin
          r = $urandom_range(9);
          if (r == 0) begin
            send_word(CH_QUOTE, 1'b0);
            send_word(CH_QUOTE, 1'b0);
          end else if (r == 1) begin
            send_word(CH_COMMA, 1'b0);
          end else begin
            send_word(text_byte(), 1'b0);
          end
        end
        // Now and then the quote is left open up to the line end.
        if ($urandom_range(9) != 0) send_word(CH_QUOTE, 1'b0);
        if ($urandom_range(9) == 0) send_word(text_byte(), 1'b0);
      end else begin
        repeat (len) send_word(text_byte(), 1'b0);
      end
    end
    if (nf > 0 && $urandom_range(6) == 0) send_word(CH_COMMA, 1'b0);
    r = $urandom_range(9);
    if (r < 6) begin
      send_word(CH_LF, 1'b0);
    end else if (r < 8) begin
      send_word(CH_CR, 1'b0);
      send_word(CH_LF, 1'b0);
    end else begin
      send_word(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(8, 1)) begin
      case ($urandom_range(7))
        0: b = CH_QUOTE;
        1: b = CH_COMMA;
        2: b = CH_CR;
        3: b = CH_LF;
        4: b = MARK0;
        5: b = MARK1;
        default: b = 8'($urandom_range(255));
      endcase
      send_word(b, $urandom_range(19) == 0);
    end
  endtask

  task automatic drain_tokens();
    text.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic run_phase(input int src, input int rx, input int count, input bit hold);
    int goal;
    src_idle_pct = src;
    rx_stall_pct = rx;
    goal = words_sent + count;
    while (words_sent < goal) begin
      // Halfway through, the receiver stops for a long stretch while words keep coming.
      if (hold && words_sent >= goal - count / 2) begin
        hold = 1'b0;
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end
      if ($urandom_range(99) < 15) send_noise();
      else send_record();
    end
    drain_tokens();
  endtask

  initial begin
    sb = new();
    text.valid <= 1'b0;
    text.in_byte <= 8'h00;
    text.stream_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_words = '{
      {1'b0, CH_LF},
      {1'b0, MARK0}, {1'b0, MARK1}, {1'b0, MARK2}, {1'b0, CH_LF},
      {1'b0, MARK0}, {1'b0, CH_CR}, {1'b0, 8'h00}, {1'b0, CH_LF},
      {1'b0, CH_COMMA},
      {1'b0, CH_QUOTE}, {1'b0, CH_COMMA}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE},
      {1'b0, CH_QUOTE}, {1'b0, 8'h58}, {1'b0, CH_LF},
      {1'b0, 8'hFF}, {1'b0, CH_QUOTE}, {1'b0, CH_COMMA}, {1'b0, CH_LF},
      {1'b0, CH_QUOTE}, {1'b0, 8'h7F}, {1'b0, CH_LF},
      {1'b0, MARK0}, {1'b0, MARK1}, {1'b1, 8'hA5},
      {1'b1, 8'h00}
    };
    foreach (dir_words[i]) send_word(dir_words[i][7:0], dir_words[i][8]);
    drain_tokens();

    run_phase(0, 0, PHASE_WORDS, 1'b1);
    run_phase(50, 0, PHASE_WORDS, 1'b0);
    run_phase(0, 50, PHASE_WORDS, 1'b0);
    run_phase(24, 24, PHASE_WORDS, 1'b0);

    // Let any stray word show up before the verdict.
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("%0t: %0d mismatches, %0d tokens never arrived",
               $time, sb.errors, sb.pending.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### csv_field_tokenizer.f
rtl/core/csvt_pkg.sv
rtl/core/csvt_ifs.sv
rtl/core/csvt_front.sv
rtl/core/csvt_queue.sv
rtl/core/csvt_back.sv
rtl/core/csv_field_tokenizer.sv
dv/tb_top.sv
